// File: design/dfhd_pkg.sv
// shared types, constants and the 7-segment decoder for the desk frame height decoder
`default_nettype none
package dfhd_pkg;

    localparam int BUFFER_BYTES = 16;
    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);
    localparam int CMP_W = 10;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] START_A = 8'h9b;
    localparam logic [7:0] START_B = 8'h98;
    localparam logic [7:0] END_BYTE = 8'h9d;
    localparam logic [7:0] HEIGHT_TYPE = 8'h12;
    localparam logic [7:0] HEIGHT_LEN = 8'd7;

    localparam logic [1:0] EV_HEIGHT = 2'd0;
    localparam logic [1:0] EV_BAD_END = 2'd1;
    localparam logic [1:0] EV_OVERSIZE = 2'd2;

    localparam int SEG_W = 4;
    localparam logic [SEG_W-1:0] SEG_MINUS = 4'd10;
    localparam logic [SEG_W-1:0] SEG_BLANK = 4'd14;
    localparam logic [SEG_W-1:0] SEG_UNKNOWN = 4'd15;

    localparam int RAW_W = 11;
    localparam int HEIGHT_W = 14;

    typedef enum logic [1:0] {
        JOB_HEIGHT = 2'd0,
        JOB_BAD_END = 2'd1,
        JOB_OVERSIZE = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t kind;
        logic [7:0] hund;
        logic [7:0] tens;
        logic [7:0] ones;
    } job_t;

    function automatic logic [SEG_W-1:0] seg_decode(input logic [7:0] b);
        logic [6:0] s;
        logic [SEG_W-1:0] r;
        s = b[6:0];
        unique case (s)
            7'h00: r = SEG_BLANK;
            7'h3f: r = 4'd0;
            7'h06: r = 4'd1;
            7'h5b: r = 4'd2;
            7'h4f: r = 4'd3;
            7'h66: r = 4'd4;
            7'h6d: r = 4'd5;
            7'h7d: r = 4'd6;
            7'h07: r = 4'd7;
            7'h7f: r = 4'd8;
            7'h6f: r = 4'd9;
            7'h40: r = SEG_MINUS;
            default: r = SEG_UNKNOWN;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// File: design/dfhd_front.sv
// frame tracker: counts frame bytes, captures fields and classifies finished frames
`default_nettype none
module dfhd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            take,
    input  wire logic [7:0]      rx_byte,
    output logic                 push,
    output dfhd_pkg::job_t       job
);

    logic [dfhd_pkg::CNT_W-1:0] count_reg, count_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] hund_reg, hund_next;
    logic [7:0] tens_reg, tens_next;
    logic [7:0] ones_reg, ones_next;

    logic [dfhd_pkg::CMP_W-1:0] count_wide;
    logic [dfhd_pkg::CMP_W-1:0] total;
    logic [dfhd_pkg::CMP_W-1:0] count_inc;
    logic hunting;
    logic at_len;
    logic oversize;
    logic closing_byte;

    always_comb
    begin
        count_wide = dfhd_pkg::CMP_W'(count_reg);
        count_inc  = count_wide + dfhd_pkg::CMP_W'(1);
        hunting    = (count_wide == dfhd_pkg::CMP_W'(0));
        at_len     = (count_wide == dfhd_pkg::CMP_W'(1));
        len_next   = at_len ? rx_byte : len_reg;
        type_next  = (count_wide == dfhd_pkg::CMP_W'(2)) ? rx_byte : type_reg;
        hund_next  = (count_wide == dfhd_pkg::CMP_W'(3)) ? rx_byte : hund_reg;
        tens_next  = (count_wide == dfhd_pkg::CMP_W'(4)) ? rx_byte : tens_reg;
        ones_next  = (count_wide == dfhd_pkg::CMP_W'(5)) ? rx_byte : ones_reg;
        total      = dfhd_pkg::CMP_W'(len_next) + dfhd_pkg::CMP_W'(2);
        oversize   = at_len && (total > dfhd_pkg::CMP_W'(dfhd_pkg::BUFFER_BYTES));
        closing_byte = !hunting && !oversize && (count_inc >= total);

        count_next = count_reg;
        push       = 1'b0;
        job.kind   = dfhd_pkg::JOB_HEIGHT;
        job.hund   = hund_next;
        job.tens   = tens_next;
        job.ones   = ones_next;

        if (hunting)
        begin
            if (rx_byte == dfhd_pkg::START_A || rx_byte == dfhd_pkg::START_B)
            begin
                count_next = dfhd_pkg::CNT_W'(1);
            end
        end
        else if (oversize)
        begin
            count_next = '0;
            push       = 1'b1;
            job.kind   = dfhd_pkg::JOB_OVERSIZE;
        end
        else if (closing_byte)
        begin
            count_next = '0;
            if (rx_byte != dfhd_pkg::END_BYTE)
            begin
                push     = 1'b1;
                job.kind = dfhd_pkg::JOB_BAD_END;
            end
            else if (type_next == dfhd_pkg::HEIGHT_TYPE && len_next == dfhd_pkg::HEIGHT_LEN)
            begin
                push     = 1'b1;
                job.kind = dfhd_pkg::JOB_HEIGHT;
            end
        end
        else
        begin
            count_next = dfhd_pkg::CNT_W'(count_inc);
        end

        push = push && take;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            len_reg   <= '0;
            type_reg  <= '0;
            hund_reg  <= '0;
            tens_reg  <= '0;
            ones_reg  <= '0;
        end
        else if (take)
        begin
            count_reg <= count_next;
            len_reg   <= len_next;
            type_reg  <= type_next;
            hund_reg  <= hund_next;
            tens_reg  <= tens_next;
            ones_reg  <= ones_next;
        end
    end

endmodule
`default_nettype wire

// File: design/dfhd_queue.sv
// small fifo of classified frame jobs between the front and back parts
`default_nettype none
module dfhd_queue (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire dfhd_pkg::job_t  push_job,
    output logic                 full,
    output logic                 head_valid,
    output dfhd_pkg::job_t       head_job,
    input  wire logic            pop
);

    dfhd_pkg::job_t mem [dfhd_pkg::Q_DEPTH];

    logic [dfhd_pkg::Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dfhd_pkg::Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dfhd_pkg::Q_CNT_W-1:0] fill_reg, fill_next;

    always_comb
    begin
        full        = (fill_reg == dfhd_pkg::Q_CNT_W'(dfhd_pkg::Q_DEPTH));
        head_valid  = (fill_reg != '0);
        head_job    = mem[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + dfhd_pkg::Q_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + dfhd_pkg::Q_PTR_W'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (push && !pop)
        begin
            fill_next = fill_reg + dfhd_pkg::Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - dfhd_pkg::Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

// File: design/dfhd_back.sv
// event executor: decodes height digits, filters repeats and drives the output register
`default_nettype none
module dfhd_back (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              head_valid,
    input  wire dfhd_pkg::job_t                    head_job,
    output logic                                   pop,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             event_kind,
    output logic [dfhd_pkg::HEIGHT_W-1:0]          height_tenths,
    output logic                                   had_point
);

    logic [dfhd_pkg::SEG_W-1:0] h_dig, t_dig, o_dig, h_val;
    logic [dfhd_pkg::RAW_W-1:0] raw;
    logic [dfhd_pkg::HEIGHT_W-1:0] tenths;
    logic pt;
    logic reading_ok;
    logic emit;
    logic out_free;

    logic valid_reg, valid_next;
    logic [1:0] kind_reg, kind_next;
    logic [dfhd_pkg::HEIGHT_W-1:0] height_reg, height_next;
    logic point_reg, point_next;
    logic [dfhd_pkg::HEIGHT_W-1:0] last_reg, last_next;
    logic known_reg, known_next;

    always_comb
    begin
        h_dig = dfhd_pkg::seg_decode(head_job.hund);
        t_dig = dfhd_pkg::seg_decode(head_job.tens);
        o_dig = dfhd_pkg::seg_decode(head_job.ones);
        h_val = (h_dig == dfhd_pkg::SEG_BLANK) ? '0 : h_dig;
        pt    = head_job.tens[7];

        reading_ok = 1'b1;
        if (h_dig == dfhd_pkg::SEG_BLANK && t_dig == dfhd_pkg::SEG_BLANK
            && o_dig == dfhd_pkg::SEG_BLANK)
        begin
            reading_ok = 1'b0;
        end
        if (h_val == dfhd_pkg::SEG_UNKNOWN
            || t_dig == dfhd_pkg::SEG_UNKNOWN || t_dig == dfhd_pkg::SEG_BLANK
            || o_dig == dfhd_pkg::SEG_UNKNOWN || o_dig == dfhd_pkg::SEG_BLANK)
        begin
            reading_ok = 1'b0;
        end
        if (h_val == '0 && t_dig == '0 && o_dig == '0)
        begin
            reading_ok = 1'b0;
        end
        if (t_dig == dfhd_pkg::SEG_MINUS)
        begin
            reading_ok = 1'b0;
        end

        raw = dfhd_pkg::RAW_W'(h_val) * dfhd_pkg::RAW_W'(100)
            + dfhd_pkg::RAW_W'(t_dig) * dfhd_pkg::RAW_W'(10)
            + dfhd_pkg::RAW_W'(o_dig);
        tenths = pt ? dfhd_pkg::HEIGHT_W'(raw)
                    : dfhd_pkg::HEIGHT_W'(raw) * dfhd_pkg::HEIGHT_W'(10);

        out_free = !valid_reg || out_ready;

        emit        = 1'b0;
        kind_next   = kind_reg;
        height_next = height_reg;
        point_next  = point_reg;
        last_next   = last_reg;
        known_next  = known_reg;

        case (head_job.kind)
            dfhd_pkg::JOB_HEIGHT:
            begin
                emit        = reading_ok && !(known_reg && last_reg == tenths);
                kind_next   = dfhd_pkg::EV_HEIGHT;
                height_next = tenths;
                point_next  = pt;
            end
            dfhd_pkg::JOB_BAD_END:
            begin
                emit        = 1'b1;
                kind_next   = dfhd_pkg::EV_BAD_END;
                height_next = '0;
                point_next  = 1'b0;
            end
            dfhd_pkg::JOB_OVERSIZE:
            begin
                emit        = 1'b1;
                kind_next   = dfhd_pkg::EV_OVERSIZE;
                height_next = '0;
                point_next  = 1'b0;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        pop = head_valid && (!emit || out_free);

        valid_next = valid_reg && !out_ready;
        if (pop && emit)
        begin
            valid_next = 1'b1;
            if (head_job.kind == dfhd_pkg::JOB_HEIGHT)
            begin
                last_next  = tenths;
                known_next = 1'b1;
            end
        end

        out_valid     = valid_reg;
        event_kind    = kind_reg;
        height_tenths = height_reg;
        had_point     = point_reg;
    end

    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            kind_reg   <= kind_next;
            height_reg <= height_next;
            point_reg  <= point_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= '0;
            known_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
            known_reg <= known_next;
        end
    end

endmodule
`default_nettype wire

// File: design/desk_frame_height_decoder_core.sv
// top level of the desk frame height decoder: frame tracker, job queue and event executor
`default_nettype none
// Takes one received serial byte per transaction and reports new heights, bad end
// bytes and oversize frames, at most one result per byte. A byte is taken every
// cycle while the four-entry job queue between the frame tracker and the event
// executor has room; the executor retires one queued job per cycle into a single
// output register while that register is free or the job gives no result, so the
// input stalls only once the queue fills while out_ready holds results back. After
// the frame's closing byte a result passes the job queue and then the output register.
module desk_frame_height_decoder_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [7:0]                        rx_byte,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [1:0]                             event_kind,
    output logic [dfhd_pkg::HEIGHT_W-1:0]          height_tenths,
    output logic                                   had_point
);

    logic take;
    logic push;
    dfhd_pkg::job_t push_job;
    logic full;
    logic head_valid;
    dfhd_pkg::job_t head_job;
    logic pop;

    assign in_ready = !full;
    assign take     = in_valid && !full;

    dfhd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (rx_byte),
        .push    (push),
        .job     (push_job)
    );

    dfhd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    dfhd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_job      (head_job),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .height_tenths (height_tenths),
        .had_point     (had_point)
    );

endmodule
`default_nettype wire

// File: tb/testbench.sv
// testbench for desk_frame_height_decoder_core: byte stream stimulus with a self-checking scoreboard
`default_nettype none
module testbench;
    import dfhd_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 1250;
    localparam int QUIET_FROM = 1100;

    localparam int DIGIT_BLANK = -2;
    localparam int DIGIT_UNKNOWN = -1;
    localparam int DIGIT_MINUS = 10;

    localparam logic [6:0] SEG_PATTERNS [11] = '{
        7'h3f, 7'h06, 7'h5b, 7'h4f, 7'h66, 7'h6d, 7'h7d, 7'h07, 7'h7f, 7'h6f, 7'h40
    };

    typedef struct {
        logic [1:0]          kind;
        logic [HEIGHT_W-1:0] height;
        logic                point;
    } desk_event_t;

    class height_scoreboard;
        int unsigned   frame_pos;
        logic [7:0]    frame_len;
        logic [7:0]    type_byte;
        logic [7:0]    digit_raw [3];
        int unsigned   last_tenths;
        bit            tenths_known;
        desk_event_t   pending_events [$];
        int            errors;

        function new();
            frame_pos = 0;
            frame_len = '0;
            type_byte = '0;
            digit_raw = '{8'h00, 8'h00, 8'h00};
            last_tenths = 0;
            tenths_known = 1'b0;
            errors = 0;
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        function void add_event(logic [1:0] kind, int unsigned tenths, bit point);
            desk_event_t ev;
            ev.kind = kind;
            ev.height = tenths[HEIGHT_W-1:0];
            ev.point = point;
            pending_events.push_back(ev);
        endfunction

        function int digit_value(logic [7:0] b);
            if (b[6:0] == 7'h00)
                return DIGIT_BLANK;
            for (int i = 0; i < 11; i++)
                if (b[6:0] == SEG_PATTERNS[i])
                    return i;
            return DIGIT_UNKNOWN;
        endfunction

        function void decode_reading();
            int hund;
            int tens;
            int ones;
            int unsigned raw;
            int unsigned tenths;
            bit point;
            hund = digit_value(digit_raw[0]);
            tens = digit_value(digit_raw[1]);
            ones = digit_value(digit_raw[2]);
            if (hund == DIGIT_BLANK && tens == DIGIT_BLANK && ones == DIGIT_BLANK)
                return;
            if (hund == DIGIT_BLANK)
                hund = 0;
            if (hund < 0 || tens < 0 || ones < 0)
                return;
            if (hund == 0 && tens == 0 && ones == 0)
                return;
            if (tens == DIGIT_MINUS)
                return;
            raw = hund * 100 + tens * 10 + ones;
            point = digit_raw[1][7];
            tenths = point ? raw : raw * 10;
            if (tenths_known && last_tenths == tenths)
                return;
            last_tenths = tenths;
            tenths_known = 1'b1;
            add_event(EV_HEIGHT, tenths, point);
        endfunction

        function void predict_byte(logic [7:0] b);
            if (frame_pos == 0)
            begin
                if (b == START_A || b == START_B)
                    frame_pos = 1;
                return;
            end
            if (frame_pos == 1)
            begin
                frame_len = b;
                if (int'(b) + 2 > BUFFER_BYTES)
                begin
                    frame_pos = 0;
                    add_event(EV_OVERSIZE, 0, 1'b0);
                    return;
                end
            end
            else if (frame_pos == 2)
                type_byte = b;
            else if (frame_pos >= 3 && frame_pos <= 5)
                digit_raw[frame_pos - 3] = b;
            frame_pos++;
            if (frame_pos < int'(frame_len) + 2)
                return;
            frame_pos = 0;
            if (b != END_BYTE)
            begin
                add_event(EV_BAD_END, 0, 1'b0);
                return;
            end
            if (type_byte == HEIGHT_TYPE && frame_len == HEIGHT_LEN)
                decode_reading();
        endfunction

        function void check_event(logic [1:0] kind, logic [HEIGHT_W-1:0] height, logic point);
            desk_event_t ev;
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d height %0d point %0d",
                         $time, kind, height, point);
                errors++;
                return;
            end
            ev = pending_events.pop_front();
            if (kind !== ev.kind)
            begin
                $display("%0t: event_kind expected %0d actual %0d", $time, ev.kind, kind);
                errors++;
            end
            if (height !== ev.height)
            begin
                $display("%0t: height_tenths expected %0d actual %0d", $time, ev.height, height);
                errors++;
            end
            if (point !== ev.point)
            begin
                $display("%0t: had_point expected %0d actual %0d", $time, ev.point, point);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [7:0]          rx_byte = 8'h00;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [1:0]          event_kind;
    logic [HEIGHT_W-1:0] height_tenths;
    logic                had_point;

    height_scoreboard sb = new();
    int unsigned      cycles = 0;
    int               sent = 0;
    bit               quiet = 1'b0;
    bit               gappy = 1'b1;
    logic [7:0]       frame_bytes [$];
    logic [7:0]       prev_digits [3] = '{8'h06, 8'h3f, 8'h3f};

    desk_frame_height_decoder_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .event_kind    (event_kind),
        .height_tenths (height_tenths),
        .had_point     (had_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // every accepted transaction goes to the scoreboard at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.predict_byte(rx_byte);
            if (out_valid && out_ready)
                sb.check_event(event_kind, height_tenths, had_point);
        end
    end

    initial
    begin
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        if (gappy && !quiet && $urandom_range(0, 9) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do @(posedge clk); while (!in_ready);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_frame_bytes();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (sb.pending() != 0);
    endtask

    function automatic logic [7:0] random_start();
        return ($urandom_range(0, 1) == 0) ? START_A : START_B;
    endfunction

    function automatic logic [7:0] random_digit(int point_pct);
        int k;
        logic [7:0] b;
        k = $urandom_range(0, 99);
        if (k < 84)
            b = {1'b0, SEG_PATTERNS[$urandom_range(0, 9)]};
        else if (k < 90)
            b = {1'b0, SEG_PATTERNS[DIGIT_MINUS]};
        else if (k < 95)
            b = 8'h00;
        else
            b = {1'b0, 7'($urandom_range(0, 127))};
        b[7] = ($urandom_range(0, 99) < point_pct);
        return b;
    endfunction

    task automatic random_frame();
        int r;
        int len;
        r = $urandom_range(0, 99);
        gappy = ($urandom_range(0, 3) != 0);
        if (r < 55)
        begin
            frame_bytes.push_back(random_start());
            frame_bytes.push_back(HEIGHT_LEN);
            frame_bytes.push_back(HEIGHT_TYPE);
            if ($urandom_range(0, 99) >= 15)
            begin
                prev_digits[0] = ($urandom_range(0, 2) == 0) ? 8'h00 : random_digit(20);
                prev_digits[1] = random_digit(50);
                prev_digits[2] = random_digit(20);
            end
            foreach (prev_digits[i])
                frame_bytes.push_back(prev_digits[i]);
            frame_bytes.push_back(8'($urandom_range(0, 255)));
            frame_bytes.push_back(8'($urandom_range(0, 255)));
            frame_bytes.push_back(($urandom_range(0, 19) == 0) ?
                                  8'($urandom_range(0, 255)) : END_BYTE);
        end
        else if (r < 65)
        begin
            len = $urandom_range(0, BUFFER_BYTES - 2);
            frame_bytes.push_back(random_start());
            frame_bytes.push_back(8'(len));
            for (int i = 2; i < len + 2; i++)
                if (i == len + 1 && $urandom_range(0, 9) != 0)
                    frame_bytes.push_back(END_BYTE);
                else
                    frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        else if (r < 72)
        begin
            frame_bytes.push_back(random_start());
            frame_bytes.push_back(8'($urandom_range(BUFFER_BYTES - 1, 255)));
        end
        else if (r < 80)
        begin
            frame_bytes.push_back(random_start());
            frame_bytes.push_back(HEIGHT_LEN);
            frame_bytes.push_back(HEIGHT_TYPE);
            repeat (5) frame_bytes.push_back(8'($urandom_range(0, 255)));
            frame_bytes.push_back(END_BYTE);
        end
        else
        begin
            repeat ($urandom_range(1, 6)) frame_bytes.push_back(8'($urandom_range(0, 255)));
        end
        send_frame_bytes();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // bytes ignored while hunting, zero length, oversize lengths
        frame_bytes = '{8'h00, 8'hff, START_A, 8'h00, START_B, 8'(BUFFER_BYTES - 1),
                        START_A, 8'hff};
        send_frame_bytes();
        // largest reading: minus in hundreds and ones, without and with the point
        frame_bytes = '{START_B, HEIGHT_LEN, HEIGHT_TYPE, 8'h40, 8'h6f, 8'h40,
                        8'h00, 8'hff, END_BYTE};
        send_frame_bytes();
        frame_bytes = '{START_A, HEIGHT_LEN, HEIGHT_TYPE, 8'hc0, 8'hef, 8'hc0,
                        8'h55, 8'haa, END_BYTE};
        send_frame_bytes();
        wait_drained();

        while (sent < ITEM_TARGET)
        begin
            if (sent >= QUIET_FROM)
                quiet = 1'b1;
            if ($urandom_range(0, 299) == 0)
                wait_drained();
            random_frame();
        end

        wait_drained();
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
`default_nettype wire

// File: filelist.f
design/dfhd_pkg.sv
design/dfhd_front.sv
design/dfhd_queue.sv
design/dfhd_back.sv
design/desk_frame_height_decoder_core.sv
tb/testbench.sv
